@@ hdl/ordered_array_table_engine_assert.svh @@
// Assertion macros for the ordered array table engine.
// Included by the top level; needs nothing else.
`ifndef ORDERED_ARRAY_TABLE_ENGINE_ASSERT_SVH
`define ORDERED_ARRAY_TABLE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define OATE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define OATE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define OATE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define OATE_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/oate_pkg.sv @@
// Shared types and codes of the ordered array table engine.
// No dependencies.
`default_nettype none

package oate_pkg;

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_GET    = 3'd3;
   localparam logic [2:0] OP_UPDATE = 3'd4;
   localparam logic [2:0] OP_SEARCH = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_MISS  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_FIN,
      S_GET,
      S_SCAN,
      S_DONE
   } oate_state_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic [6:0]         found_position;
      logic [7:0]         fill_count;
      logic               is_full;
      logic               is_empty;
   } oate_rsp_type;

   typedef struct packed {
      logic         load;
      oate_rsp_type data;
   } oate_load_type;

endpackage

`default_nettype wire

@@ hdl/oate_req_if.sv @@
// Request channel of the ordered array table engine.
// No dependencies.
`default_nettype none

interface oate_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic [7:0]         position;
   logic signed [31:0] value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink (input valid, input operation, input position, input value,
                 output ready);
endinterface

`default_nettype wire

@@ hdl/oate_rsp_if.sv @@
// Response channel of the ordered array table engine.
// No dependencies.
`default_nettype none

interface oate_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] read_value;
   logic [6:0]         found_position;
   logic [7:0]         fill_count;
   logic               is_full;
   logic               is_empty;

   modport source (output valid, output status, output read_value,
                   output found_position, output fill_count, output is_full,
                   output is_empty, input ready);
   modport sink (input valid, input status, input read_value,
                 input found_position, input fill_count, input is_full,
                 input is_empty, output ready);
endinterface

`default_nettype wire

@@ hdl/ordered_array_table_engine.sv @@
// Ordered array table engine: a packed table of CAPACITY signed 32-bit words
// with a fill count. Each request on req_if does append, insert at index,
// remove at index, get, update or search, and yields one result on rsp_if
// with status, read value, found index, fill count and full/empty flags.
// Transfers happen where valid and ready are both high.
// One request is worked at a time; req_if.ready is high only while idle.
// Append, errors and unused codes go straight to the result; get and update
// read the entry first; insert and remove shift the entries between the index
// and the end; search walks up from index 0 and stops at the first match.
// The walks move one entry a cycle through the table memory, which has one
// write and one read port with registered read data; the index stepper is the
// one shared unit.
// A finished result sits in an output register; the next request is taken
// while it waits, and only the hand-over of a further result stalls.
// Synchronous reset empties the table at once; entries are not cleared.
`default_nettype none
`include "ordered_array_table_engine_assert.svh"

module ordered_array_table_engine
   import oate_pkg::*;
#(
   parameter int CAPACITY = 128
)
(
   input  wire logic  clock,
   input  wire logic  reset,
   oate_req_if.sink   req_if,
   oate_rsp_if.source rsp_if
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 8) ? CW : 8;

   oate_state_type  state_ff, state_in;
   logic [2:0]      op_ff, op_in;
   logic [AW-1:0]   paddr_ff, paddr_in;
   logic [31:0]     val_ff, val_in;
   logic [1:0]      status_ff, status_in;
   logic [31:0]     rd_ff, rd_in;
   logic [AW-1:0]   fpos_ff, fpos_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   ridx_ff, ridx_in;
   logic [AW-1:0]   rlast_ff, rlast_in;
   logic [AW-1:0]   wtag_ff, wtag_in;
   logic [AW-1:0]   wnext_ff, wnext_in;
   logic            more_ff, more_in;
   logic            pend_ff, pend_in;

   logic [31:0]     entry_ff [CAPACITY];
   logic [31:0]     rdata_ff;
   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_waddr, mem_raddr;
   logic [31:0]     mem_wdata;

   logic            accept;
   logic [PW-1:0]   pos_ext, cnt_ext;
   logic [AW-1:0]   pos_a, cnt_a, cnt_m1, step_idx;
   logic            full, empty, ins_range, idx_range, match;
   logic            space;
   oate_load_type   load_req;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept    = req_if.valid && req_if.ready;
   assign pos_ext   = PW'(req_if.position);
   assign cnt_ext   = PW'(count_ff);
   assign pos_a     = AW'(pos_ext);
   assign cnt_a     = AW'(count_ff);
   assign cnt_m1    = AW'(count_ff - CW'(1));
   assign full      = count_ff == CW'(CAPACITY);
   assign empty     = count_ff == '0;
   assign ins_range = (pos_ext > cnt_ext) || (pos_ext >= PW'(CAPACITY));
   assign idx_range = pos_ext >= cnt_ext;
   assign match     = pend_ff && (rdata_ff == val_ff);
   assign step_idx  = (op_ff == OP_INSERT) ? ridx_ff - AW'(1) : ridx_ff + AW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_if.operation) inside
                  OP_INSERT: state_in = (ins_range || full) ? S_DONE : S_SHIFT;
                  OP_REMOVE: state_in = idx_range ? S_DONE : S_SHIFT;
                  OP_GET, OP_UPDATE: state_in = idx_range ? S_DONE : S_GET;
                  OP_SEARCH: state_in = empty ? S_DONE : S_SCAN;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SHIFT: begin
            if (!more_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: state_in = S_DONE;
         S_GET: state_in = S_DONE;
         S_SCAN: begin
            if (match || (!more_ff && !pend_ff)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (space) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in     = op_ff;
      paddr_in  = paddr_ff;
      val_in    = val_ff;
      status_in = status_ff;
      rd_in     = rd_ff;
      fpos_in   = fpos_ff;
      count_in  = count_ff;
      ridx_in   = ridx_ff;
      rlast_in  = rlast_ff;
      wtag_in   = wtag_ff;
      wnext_in  = wnext_ff;
      more_in   = more_ff;
      pend_in   = pend_ff;
      mem_we    = 1'b0;
      mem_waddr = wtag_ff;
      mem_wdata = rdata_ff;
      mem_re    = 1'b0;
      mem_raddr = ridx_ff;
      load_req.load = 1'b0;
      load_req.data.status         = status_ff;
      load_req.data.read_value     = $signed(rd_ff);
      load_req.data.found_position = 7'(fpos_ff);
      load_req.data.fill_count     = 8'(count_ff);
      load_req.data.is_full        = full;
      load_req.data.is_empty       = empty;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_if.operation;
               paddr_in  = pos_a;
               val_in    = req_if.value;
               status_in = ST_OK;
               rd_in     = '0;
               fpos_in   = '0;
               pend_in   = 1'b0;
               unique case (req_if.operation) inside
                  OP_APPEND: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_a;
                        mem_wdata = req_if.value;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (ins_range) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ridx_in  = cnt_m1;
                        wnext_in = cnt_a;
                        rlast_in = pos_a;
                        more_in  = pos_ext < cnt_ext;
                     end
                  end
                  OP_REMOVE: begin
                     if (idx_range) begin
                        status_in = ST_RANGE;
                     end else begin
                        ridx_in  = pos_a + AW'(1);
                        wnext_in = pos_a;
                        rlast_in = cnt_m1;
                        more_in  = (pos_ext + PW'(1)) < cnt_ext;
                     end
                  end
                  OP_GET, OP_UPDATE: begin
                     if (idx_range) begin
                        status_in = ST_RANGE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_a;
                     end
                  end
                  OP_SEARCH: begin
                     status_in = ST_MISS;
                     ridx_in   = '0;
                     rlast_in  = cnt_m1;
                     more_in   = !empty;
                  end
                  default: begin
                     status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            mem_we = pend_ff;
            if (more_ff) begin
               mem_re   = 1'b1;
               pend_in  = 1'b1;
               wtag_in  = wnext_ff;
               wnext_in = ridx_ff;
               more_in  = ridx_ff != rlast_ff;
               ridx_in  = step_idx;
            end else begin
               pend_in = 1'b0;
            end
         end
         S_FIN: begin
            if (op_ff == OP_INSERT) begin
               mem_we    = 1'b1;
               mem_waddr = paddr_ff;
               mem_wdata = val_ff;
               count_in  = count_ff + CW'(1);
            end else begin
               count_in  = count_ff - CW'(1);
            end
         end
         S_GET: begin
            rd_in = rdata_ff;
            if (op_ff == OP_UPDATE) begin
               mem_we    = 1'b1;
               mem_waddr = paddr_ff;
               mem_wdata = val_ff;
            end
         end
         S_SCAN: begin
            if (more_ff) begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               wtag_in = ridx_ff;
               more_in = ridx_ff != rlast_ff;
               ridx_in = step_idx;
            end else begin
               pend_in = 1'b0;
            end
            if (match) begin
               status_in = ST_OK;
               fpos_in   = wtag_ff;
            end
         end
         S_DONE: begin
            load_req.load = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= entry_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         more_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         more_ff  <= more_in;
         pend_ff  <= pend_in;
      end
      op_ff     <= op_in;
      paddr_ff  <= paddr_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
      fpos_ff   <= fpos_in;
      ridx_ff   <= ridx_in;
      rlast_ff  <= rlast_in;
      wtag_ff   <= wtag_in;
      wnext_ff  <= wnext_in;
   end

   oate_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .load_req (load_req),
      .space    (space),
      .rsp_if   (rsp_if)
   );

   `OATE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY),
                    "count above capacity")
   `OATE_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_if.ready,
                    "ready after transfer")
   `OATE_ASSERT_NXT(a_scan_hit, clock, reset, (state_ff == S_SCAN) && match,
                    (state_ff == S_DONE) && (status_ff == ST_OK), "search hit lost")
   `OATE_ASSERT_NXT(a_count_step, clock, reset, 1'b1,
                    (count_ff == $past(count_ff)) ||
                    (count_ff == $past(count_ff) + CW'(1)) ||
                    (count_ff == $past(count_ff) - CW'(1)), "count jumped")

endmodule

`default_nettype wire

@@ hdl/oate_rsp_buf.sv @@
// Output register of the response channel; holds a result until transfer.
// Depends on oate_pkg and oate_rsp_if.
`default_nettype none

module oate_rsp_buf
   import oate_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire oate_load_type load_req,
   output logic               space,
   oate_rsp_if.source         rsp_if
);

   logic         valid_ff, valid_in;
   oate_rsp_type data_ff, data_in;

   assign space = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_req.load && space) begin
         valid_in = 1'b1;
         data_in  = load_req.data;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.status         = data_ff.status;
   assign rsp_if.read_value     = data_ff.read_value;
   assign rsp_if.found_position = data_ff.found_position;
   assign rsp_if.fill_count     = data_ff.fill_count;
   assign rsp_if.is_full        = data_ff.is_full;
   assign rsp_if.is_empty       = data_ff.is_empty;

endmodule

`default_nettype wire
